### design/sfd_pkg.sv
// sfd_pkg: constants and widths for the serial frame deframer.
// No dependencies; imported by serial_frame_deframer_xor_check.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned OUT_DATA_W = 40;  // 33 field bits, zero-filled to 5 bytes

	localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
	localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;

	// result kinds, carried on tlast
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

endpackage : sfd_pkg

`default_nettype wire

### design/serial_frame_deframer_xor_check.sv
// serial_frame_deframer_xor_check: byte stream deframer with XOR check.
// Depends on sfd_pkg (sync bytes, result kinds, widths).
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Width  Fields (lowest bit up)
// s_axis    in   8      tdata: in_byte[7:0]
// m_axis    out  40     tdata: data_byte[7:0] msg_id[15:8] byte_index[23:16]
//                              payload_len[31:24] check_ok[32], zero fill [39:33]
//                       tlast: result_kind (1 = end-of-frame status)
//
// Rate: one item per cycle unless the sink stalls; each accepted byte is handled by the phase
//   register and, for payload and check bytes, loads the output register in
//   the same edge. Throughput is set by the state loop.
// Output: a result appears on m_tvalid the cycle after its byte is accepted.
// Reset: arst_n low clears phase (hunting for first header), length, id,
//   running XOR, count and the output valid.
// Stalls: s_tready is high while the output register is empty or being drained
//   by m_tready; a held result blocks input only when the sink stalls.

module serial_frame_deframer_xor_check
	import sfd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input stream: in_byte[7:0]
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [BYTE_W-1:0]     s_tdata,
	// result stream: data_byte, msg_id, byte_index, payload_len, check_ok
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tlast   // result_kind
);

	typedef enum logic [2:0] {
		PH_HUNT0 = 3'd0,
		PH_HUNT1 = 3'd1,
		PH_LEN   = 3'd2,
		PH_ID    = 3'd3,
		PH_DATA  = 3'd4,
		PH_CHECK = 3'd5
	} phase_t;

	phase_t            phase_q;
	logic [BYTE_W-1:0] length_q;
	logic [BYTE_W-1:0] id_q;
	logic [BYTE_W-1:0] xor_q;
	logic [BYTE_W-1:0] count_q;

	logic              out_valid_q;
	logic              out_kind_q;
	logic [BYTE_W-1:0] out_data_q;
	logic [BYTE_W-1:0] out_id_q;
	logic [BYTE_W-1:0] out_index_q;
	logic [BYTE_W-1:0] out_len_q;
	logic              out_ok_q;

	logic              in_accept;
	logic              out_take;
	logic              out_load;
	logic [BYTE_W-1:0] len_m1;
	logic [BYTE_W-1:0] count_next;

	assign s_tready   = !out_valid_q || m_tready;
	assign in_accept  = s_tvalid && s_tready;
	assign out_take   = out_valid_q && m_tready;
	// payload and check bytes load a result
	assign out_load   = in_accept && (phase_q == PH_DATA || phase_q == PH_CHECK);
	assign len_m1     = length_q - BYTE_W'(1);
	assign count_next = count_q + BYTE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT0;
			length_q    <= '0;
			id_q        <= '0;
			xor_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_PAYLOAD;
			out_data_q  <= '0;
			out_id_q    <= '0;
			out_index_q <= '0;
			out_len_q   <= '0;
			out_ok_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			if (in_accept) begin
				unique case (phase_q)
					PH_HUNT0: begin
						if (s_tdata == SYNC_FIRST) begin
							phase_q <= PH_HUNT1;
						end
					end
					PH_HUNT1: begin
						// broken header: back to first byte, no re-check of this one
						phase_q <= (s_tdata == SYNC_SECOND) ? PH_LEN : PH_HUNT0;
					end
					PH_LEN: begin
						length_q <= s_tdata;
						xor_q    <= s_tdata;
						count_q  <= '0;
						// zero length is dropped
						phase_q  <= (s_tdata == '0) ? PH_HUNT0 : PH_ID;
					end
					PH_ID: begin
						id_q    <= s_tdata;
						xor_q   <= xor_q ^ s_tdata;
						// length one: no payload, check follows
						phase_q <= (length_q == BYTE_W'(1)) ? PH_CHECK : PH_DATA;
					end
					PH_DATA: begin
						xor_q       <= xor_q ^ s_tdata;
						count_q     <= count_next;
						out_kind_q  <= KIND_PAYLOAD;
						out_data_q  <= s_tdata;
						out_id_q    <= id_q;
						out_index_q <= count_q;
						out_len_q   <= len_m1;
						out_ok_q    <= 1'b0;
						if (count_next == len_m1) begin
							phase_q <= PH_CHECK;
						end
					end
					PH_CHECK: begin
						out_kind_q  <= KIND_STATUS;
						out_data_q  <= '0;
						out_id_q    <= id_q;
						out_index_q <= '0;
						out_len_q   <= len_m1;
						out_ok_q    <= (s_tdata == xor_q);
						phase_q     <= PH_HUNT0;
					end
					default: begin
						phase_q <= PH_HUNT0;
					end
				endcase
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_kind_q;
	assign m_tdata  = {{(OUT_DATA_W - 4*BYTE_W - 1){1'b0}}, out_ok_q, out_len_q,
	                   out_index_q, out_id_q, out_data_q};

	// status items carry zero data and index
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[7:0] == '0 && m_tdata[23:16] == '0))
		else $error("status item with nonzero data or index");

	// payload items never report check_ok
	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !m_tdata[32])
		else $error("payload item with check_ok set");

	// a check byte always yields a status item next cycle
	a_check_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && phase_q == PH_CHECK) |=> (m_tvalid && m_tlast && phase_q == PH_HUNT0))
		else $error("check byte did not produce status item");

	// sync bytes accepted while m_tready is high leave no result pending
	a_hunt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (phase_q == PH_HUNT0 || phase_q == PH_HUNT1) && m_tready)
		|=> !m_tvalid)
		else $error("result produced while hunting");

endmodule : serial_frame_deframer_xor_check

`default_nettype wire
